>>> design/quaternion_to_euler_unwrap_top_assert.svh
// Assertion macros for the checker of the quaternion to Euler block.
// Depends on nothing; included by the checker module.
`ifndef QUATERNION_TO_EULER_UNWRAP_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_UNWRAP_TOP_ASSERT_SVH

// Clocked property with synchronous active-low reset gating
`define Q2E_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Field range check while a result is presented
`define Q2E_ASSERT_RANGE(lbl, clk, rst_n, vld, sig, lo, hi, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        vld |-> ((sig >= lo) && (sig <= hi))) else $error(msg);

`endif

>>> design/q2e_pkg.sv
// Shared types, constants and the CORDIC angle table for the quaternion to Euler block.
// Depends on nothing.
`default_nettype none
package q2e_pkg;
    localparam int CW = 37;          // CORDIC x/y datapath width
    localparam int ZW = 28;          // CORDIC angle accumulator width (deg, Q16)
    localparam int MW = 32;          // multiplier operand width
    localparam int NW = 61;          // square root radicand width

    localparam logic signed [ZW-1:0] DEG180_Q16 = 28'sd11796480;
    localparam logic signed [ZW-1:0] DEG90_64   = 28'sd5760;
    localparam logic signed [ZW-1:0] DEG180_64  = 28'sd11520;
    localparam logic [14:0] YAW_HI_64 = 15'd21760;
    localparam logic [14:0] YAW_LO_64 = 15'd1280;
    localparam logic signed [MW-1:0] TURN_64 = 32'sd23040;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_VMUL, S_VACC, S_SQRT,
        S_RGO, S_RWAIT, S_PGO, S_PWAIT, S_YGO, S_YWAIT,
        S_UNWRAP, S_TMUL, S_TACC
    } t_state;

    // atan(2^-i) in degrees, Q16
    function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = 28'sd2949120;
            5'd1:  v = 28'sd1740967;
            5'd2:  v = 28'sd919879;
            5'd3:  v = 28'sd466945;
            5'd4:  v = 28'sd234379;
            5'd5:  v = 28'sd117304;
            5'd6:  v = 28'sd58666;
            5'd7:  v = 28'sd29335;
            5'd8:  v = 28'sd14668;
            5'd9:  v = 28'sd7334;
            5'd10: v = 28'sd3667;
            5'd11: v = 28'sd1833;
            5'd12: v = 28'sd917;
            5'd13: v = 28'sd458;
            5'd14: v = 28'sd229;
            5'd15: v = 28'sd115;
            5'd16: v = 28'sd57;
            5'd17: v = 28'sd29;
            5'd18: v = 28'sd14;
            5'd19: v = 28'sd7;
            5'd20: v = 28'sd4;
            5'd21: v = 28'sd2;
            5'd22: v = 28'sd1;
            default: v = 28'sd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

>>> design/q2e_mul.sv
// Shared registered signed multiplier.
// Depends on q2e_pkg.
`default_nettype none
module q2e_mul (
    input  wire                                 i_clk,
    input  wire  logic signed [q2e_pkg::MW-1:0] i_a,
    input  wire  logic signed [q2e_pkg::MW-1:0] i_b,
    output logic signed [2*q2e_pkg::MW-1:0]     o_p
);
    // one product per cycle, registered
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule
`default_nettype wire

>>> design/q2e_isqrt.sv
// Bit-pair iterative floor square root, one result bit per cycle.
// Depends on q2e_pkg.
`default_nettype none
module q2e_isqrt (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  logic [q2e_pkg::NW-1:0] i_n,
    output logic                         o_done,
    output logic [30:0]                  o_root
);
    logic [q2e_pkg::NW-1:0] r_rem;
    logic [q2e_pkg::NW:0]   r_root;
    logic [q2e_pkg::NW-1:0] r_bit;
    logic                   r_busy;
    logic [q2e_pkg::NW:0]   trial;

    assign trial  = r_root + {1'b0, r_bit};
    assign o_root = r_root[30:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_n;
            r_root <= '0;
            r_bit  <= {1'b1, {(q2e_pkg::NW-1){1'b0}}};
        end else if (r_busy) begin
            if ({1'b0, r_rem} >= trial) begin
                r_rem  <= r_rem - trial[q2e_pkg::NW-1:0];
                r_root <= (r_root >> 1) + {1'b0, r_bit};
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end
endmodule
`default_nettype wire

>>> design/q2e_cordic.sv
// Iterative vectoring CORDIC atan2, result in 1/64 degree.
// Depends on q2e_pkg.
`default_nettype none
module q2e_cordic #(
    parameter int STEPS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire  logic signed [q2e_pkg::CW-1:0] i_y,
    input  wire  logic signed [q2e_pkg::CW-1:0] i_x,
    output logic                                o_done,
    output logic signed [14:0]                  o_angle
);
    localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [SW-1:0] LAST = SW'(STEPS - 1);

    logic signed [q2e_pkg::CW-1:0] r_x, r_y, sh_x, sh_y;
    logic signed [q2e_pkg::ZW-1:0] r_z, tab, zr;
    logic [SW-1:0]                 r_step;
    logic                          r_busy, r_fin;

    assign sh_x = r_x >>> r_step;
    assign sh_y = r_y >>> r_step;
    assign tab  = q2e_pkg::atan_tab(5'(r_step));
    assign zr   = (r_z + 28'sd512) >>> 10;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                if (i_x == '0) begin
                    o_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= '0;
                end
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                o_done <= 1'b1;
            end
        end
    end

    // rotation datapath and result
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_x == '0) begin
                o_angle <= (i_y >= 0) ? 15'(q2e_pkg::DEG90_64) : 15'(-q2e_pkg::DEG90_64);
            end else if (i_x < 0) begin
                r_x <= -i_x;
                r_y <= -i_y;
                r_z <= (i_y >= 0) ? q2e_pkg::DEG180_Q16 : -q2e_pkg::DEG180_Q16;
            end else begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + sh_y;
                r_y <= r_y - sh_x;
                r_z <= r_z + tab;
            end else begin
                r_x <= r_x - sh_y;
                r_y <= r_y + sh_x;
                r_z <= r_z - tab;
            end
        end else if (r_fin) begin
            if (zr > q2e_pkg::DEG180_64) begin
                o_angle <= 15'(q2e_pkg::DEG180_64);
            end else if (zr < -q2e_pkg::DEG180_64) begin
                o_angle <= 15'(-q2e_pkg::DEG180_64);
            end else begin
                o_angle <= 15'(zr);
            end
        end
    end
endmodule
`default_nettype wire

>>> design/quaternion_to_euler_unwrap_top.sv
// Top level: sequencer over a shared multiplier, square root and CORDIC unit.
// Depends on q2e_pkg, q2e_mul, q2e_isqrt, q2e_cordic.
//
//  channel | valid         | stall         | payload
//  --------+---------------+---------------+----------------------------------------------
//  in      | i_in_valid    | o_in_stall    | i_quat_w, i_quat_x, i_quat_y, i_quat_z
//  out     | o_out_valid   | i_out_stall   | o_roll_angle, o_pitch_angle, o_yaw_unwrapped,
//          |               |               | o_turn_saturated
//
// One request at a time: from one acceptance to the next with a free result side it runs 11
// products on the shared multiplier, the square root, an atan2 on the CORDIC unit for each
// of roll, pitch and yaw, unwrap, turn scaling and load; a zero-x atan2 skips the iterations.
// o_in_stall is high from acceptance until the result is loaded into the output register.
// Reset is synchronous; it clears the turn count, the previous yaw and all control state.
// A stalled output holds its result; the next request may be accepted meanwhile.
`default_nettype none
module quaternion_to_euler_unwrap_top #(
    parameter int CORDIC_STEPS    = 16,
    parameter int TURN_COUNT_BITS = 11
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  logic signed [15:0] i_quat_w,
    input  wire  logic signed [15:0] i_quat_x,
    input  wire  logic signed [15:0] i_quat_y,
    input  wire  logic signed [15:0] i_quat_z,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic signed [14:0]  o_roll_angle,
    output logic signed [13:0]  o_pitch_angle,
    output logic signed [25:0]  o_yaw_unwrapped,
    output logic                o_turn_saturated
);
    localparam int TB = TURN_COUNT_BITS;
    localparam logic signed [TB-1:0] TC_MAX = {1'b0, {(TB-1){1'b1}}};
    localparam logic signed [TB-1:0] TC_MIN = -TC_MAX;
    localparam int CW = q2e_pkg::CW;
    localparam int MW = q2e_pkg::MW;

    q2e_pkg::t_state r_state, n_state;

    logic signed [15:0] r_w, r_x, r_y, r_z;
    logic [3:0]         r_k;
    logic signed [32:0] r_ry, r_rx, r_ap, r_yy, r_yx, prod33;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [2*MW-1:0] prod;
    logic signed [33:0] v2, v;
    logic [30:0]        r_c;
    logic signed [14:0] r_roll, angle;
    logic signed [13:0] r_pitch;
    logic [14:0]        r_yaw, r_prev_yaw;
    logic signed [TB-1:0] r_tc;
    logic               r_sat;
    logic               out_load, sq_done, cor_done, cor_start, sq_start;
    logic [30:0]        sq_root;
    logic signed [CW-1:0] cor_y, cor_x;
    logic signed [33:0] one30;

    assign one30  = 34'sd1 <<< 30;
    assign prod33 = 33'(prod);
    assign v2     = {r_ap, 1'b0};
    assign v      = (v2 > one30) ? one30 : ((v2 < -one30) ? -one30 : v2);
    assign o_in_stall = (r_state != q2e_pkg::S_IDLE);
    assign out_load   = (r_state == q2e_pkg::S_TACC) && (!o_out_valid || !i_out_stall);
    assign sq_start   = (r_state == q2e_pkg::S_VACC);
    assign cor_start  = (r_state == q2e_pkg::S_RGO) || (r_state == q2e_pkg::S_PGO) ||
                        (r_state == q2e_pkg::S_YGO);

    q2e_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(prod));

    q2e_isqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start),
        .i_n((61'(1) << 60) - prod[60:0]),
        .o_done(sq_done), .o_root(sq_root)
    );

    q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cor_start),
        .i_y(cor_y), .i_x(cor_x), .o_done(cor_done), .o_angle(angle)
    );

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            q2e_pkg::S_MUL: begin
                case (r_k)
                    4'd0: begin mul_a = MW'(r_w); mul_b = MW'(r_x); end
                    4'd1: begin mul_a = MW'(r_y); mul_b = MW'(r_z); end
                    4'd2: begin mul_a = MW'(r_x); mul_b = MW'(r_x); end
                    4'd3: begin mul_a = MW'(r_y); mul_b = MW'(r_y); end
                    4'd4: begin mul_a = MW'(r_z); mul_b = MW'(r_z); end
                    4'd5: begin mul_a = MW'(r_w); mul_b = MW'(r_y); end
                    4'd6: begin mul_a = MW'(r_z); mul_b = MW'(r_x); end
                    4'd7: begin mul_a = MW'(r_x); mul_b = MW'(r_y); end
                    4'd8: begin mul_a = MW'(r_w); mul_b = MW'(r_z); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            q2e_pkg::S_VMUL: begin
                mul_a = MW'(v);
                mul_b = MW'(v);
            end
            // turn product stays on the multiplier while the load waits
            q2e_pkg::S_TMUL, q2e_pkg::S_TACC: begin
                mul_a = MW'(r_tc);
                mul_b = q2e_pkg::TURN_64;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // CORDIC operand select
    always_comb begin
        cor_y = '0;
        cor_x = '0;
        case (r_state)
            q2e_pkg::S_RGO: begin
                cor_y = CW'($signed({r_ry, 1'b0}));
                cor_x = CW'(one30 - $signed({r_rx, 1'b0}));
            end
            q2e_pkg::S_PGO: begin
                cor_y = CW'(v);
                cor_x = CW'({1'b0, r_c});
            end
            q2e_pkg::S_YGO: begin
                cor_y = CW'($signed({r_yy, 1'b0}));
                cor_x = CW'(one30 - $signed({r_yx, 1'b0}));
            end
            default: begin
                cor_y = '0;
                cor_x = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            q2e_pkg::S_IDLE:   if (i_in_valid) n_state = q2e_pkg::S_MUL;
            q2e_pkg::S_MUL:    n_state = q2e_pkg::S_ACC;
            q2e_pkg::S_ACC:    n_state = (r_k == 4'd8) ? q2e_pkg::S_VMUL : q2e_pkg::S_MUL;
            q2e_pkg::S_VMUL:   n_state = q2e_pkg::S_VACC;
            q2e_pkg::S_VACC:   n_state = q2e_pkg::S_SQRT;
            q2e_pkg::S_SQRT:   if (sq_done) n_state = q2e_pkg::S_RGO;
            q2e_pkg::S_RGO:    n_state = q2e_pkg::S_RWAIT;
            q2e_pkg::S_RWAIT:  if (cor_done) n_state = q2e_pkg::S_PGO;
            q2e_pkg::S_PGO:    n_state = q2e_pkg::S_PWAIT;
            q2e_pkg::S_PWAIT:  if (cor_done) n_state = q2e_pkg::S_YGO;
            q2e_pkg::S_YGO:    n_state = q2e_pkg::S_YWAIT;
            q2e_pkg::S_YWAIT:  if (cor_done) n_state = q2e_pkg::S_UNWRAP;
            q2e_pkg::S_UNWRAP: n_state = q2e_pkg::S_TMUL;
            q2e_pkg::S_TMUL:   n_state = q2e_pkg::S_TACC;
            q2e_pkg::S_TACC:   if (out_load) n_state = q2e_pkg::S_IDLE;
            default:           n_state = q2e_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= q2e_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // product accumulation and angle capture
    always_ff @(posedge i_clk) begin
        case (r_state)
            q2e_pkg::S_IDLE: begin
                r_w <= i_quat_w;
                r_x <= i_quat_x;
                r_y <= i_quat_y;
                r_z <= i_quat_z;
                r_k <= '0;
            end
            q2e_pkg::S_ACC: begin
                r_k <= r_k + 4'd1;
                case (r_k)
                    4'd0: r_ry <= prod33;
                    4'd1: r_ry <= r_ry + prod33;
                    4'd2: r_rx <= prod33;
                    4'd3: begin r_rx <= r_rx + prod33; r_yx <= prod33; end
                    4'd4: r_yx <= r_yx + prod33;
                    4'd5: r_ap <= prod33;
                    4'd6: r_ap <= r_ap - prod33;
                    4'd7: r_yy <= prod33;
                    4'd8: r_yy <= r_yy + prod33;
                    default: r_yy <= r_yy;
                endcase
            end
            q2e_pkg::S_SQRT: begin
                r_c <= sq_root;
            end
            q2e_pkg::S_RWAIT: begin
                r_roll <= angle;
            end
            q2e_pkg::S_PWAIT: begin
                if (angle > 15'sd5760) begin
                    r_pitch <= 14'sd5760;
                end else if (angle < -15'sd5760) begin
                    r_pitch <= -14'sd5760;
                end else begin
                    r_pitch <= 14'(angle);
                end
            end
            q2e_pkg::S_YWAIT: begin
                r_yaw <= 15'(angle + 15'sd11520);
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // yaw unwrap state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_yaw <= '0;
            r_tc       <= '0;
            r_sat      <= 1'b0;
        end else if (r_state == q2e_pkg::S_UNWRAP) begin
            r_sat      <= 1'b0;
            r_prev_yaw <= r_yaw;
            if (r_prev_yaw > q2e_pkg::YAW_HI_64 && r_yaw < q2e_pkg::YAW_LO_64) begin
                if (r_tc >= TC_MAX) begin
                    r_sat <= 1'b1;
                end else begin
                    r_tc <= r_tc + 1'b1;
                end
            end else if (r_prev_yaw < q2e_pkg::YAW_LO_64 && r_yaw > q2e_pkg::YAW_HI_64) begin
                if (r_tc <= TC_MIN) begin
                    r_sat <= 1'b1;
                end else begin
                    r_tc <= r_tc - 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_roll_angle     <= r_roll;
            o_pitch_angle    <= r_pitch;
            o_yaw_unwrapped  <= 26'(prod) + 26'({1'b0, r_yaw});
            o_turn_saturated <= r_sat;
        end
    end
endmodule
`default_nettype wire

>>> design/q2e_checker.sv
// Port-level checker for the quaternion to Euler block, bound to the top level.
// Depends on quaternion_to_euler_unwrap_top_assert.svh.
`default_nettype none
`include "quaternion_to_euler_unwrap_top_assert.svh"
module q2e_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                o_in_stall,
    input wire                o_out_valid,
    input wire                i_out_stall,
    input wire logic signed [14:0] o_roll_angle,
    input wire logic signed [13:0] o_pitch_angle
);
    // a held result stays presented
    `Q2E_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid, "result dropped while stalled")
    // an accepted request makes the block busy
    `Q2E_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "not busy after accept")
    // result can only appear while the block finishes an item
    `Q2E_ASSERT(a_out_from_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall), "result without a request")
    `Q2E_ASSERT_RANGE(a_roll_rng, i_clk, i_rst_n, o_out_valid, o_roll_angle, -15'sd11520, 15'sd11520, "roll out of range")
    `Q2E_ASSERT_RANGE(a_pitch_rng, i_clk, i_rst_n, o_out_valid, o_pitch_angle, -14'sd5760, 14'sd5760, "pitch out of range")
endmodule

bind quaternion_to_euler_unwrap_top q2e_checker u_q2e_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
    .o_roll_angle(o_roll_angle), .o_pitch_angle(o_pitch_angle)
);
`default_nettype wire
